// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the neighbor prefix lookup.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/core/npl_pkg.sv =====
// Package with shared types and constants of the neighbor prefix lookup.
`default_nettype none

package npl_pkg;

   localparam int NPL_TABLE_DEPTH = 32;

   localparam int OPCODE_W = 2;
   localparam int SLOT_W   = 5;
   localparam int IP_W     = 32;
   localparam int PREFIX_W = 6;
   localparam int HW_W     = 48;

   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 56;

   // Bit offsets of the request fields inside req_tdata.
   localparam int SLOT_LSB   = 0;
   localparam int IP_LSB     = SLOT_LSB + SLOT_W;
   localparam int MASK_LSB   = IP_LSB + IP_W;
   localparam int MASKED_LSB = MASK_LSB + IP_W;
   localparam int PREFIX_LSB = MASKED_LSB + IP_W;
   localparam int HW_LSB     = PREFIX_LSB + PREFIX_W;
   localparam int DST_LSB    = HW_LSB + HW_W;

   localparam logic [OPCODE_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

   localparam logic [PREFIX_W-1:0] HOST_PREFIX = 6'd1;

   typedef struct packed {
      logic [IP_W-1:0]     ip;
      logic [IP_W-1:0]     mask;
      logic [IP_W-1:0]     masked;
      logic [PREFIX_W-1:0] prefix;
      logic [HW_W-1:0]     hw;
   } entry_type;

   typedef struct packed {
      logic host_hit;
      logic net_hit;
   } match_type;

endpackage

`default_nettype wire

// ===== rtl/core/neighbor_prefix_lookup.sv =====
// Top level of the neighbor prefix lookup: table memory, scan sequencer, result register.
//
//  channel  dir  ports                                  carries
//  req      in   req_tvalid req_tready req_tdata tuser  write, lookup or clear request
//  rsp      out  rsp_tvalid rsp_tready rsp_tdata        found flag and hardware address
//
// A write request is stored at the edge that accepts it. A clear request, and reset, sweep
// the valid memory one slot per cycle with req_tready low.
// A lookup reads one slot per cycle from the single table read port into the shared
// matcher, scores each slot from the read register, then loads the result register.
// req_tready is low while a clear or lookup is in progress. A held result does not
// stop requests; a new lookup waits at its end until the result register is free.
`default_nettype none

module neighbor_prefix_lookup #(
   parameter int TABLE_DEPTH = npl_pkg::NPL_TABLE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // slot, new_ip, new_mask, new_masked, new_prefix, new_hw, lookup_ip, zero fill
   input  logic [npl_pkg::REQ_DATA_W-1:0]    req_tdata,
   // opcode
   input  logic [npl_pkg::OPCODE_W-1:0]      req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // found, hw_addr, zero fill
   output logic [npl_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import npl_pkg::*;

   localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
   localparam int SLOT_EXT_W = IDX_W + SLOT_W;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_SEND  = 4'b1000
   } state_type;

   // Table storage: payload and valid flags, one write and one read port each.
   entry_type tbl_mem   [TABLE_DEPTH];
   logic      valid_mem [TABLE_DEPTH];

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                pend_ff, pend_in;
   logic                last_ff, last_in;
   logic                hit_ff, hit_in;
   logic                stop_ff, stop_in;
   logic [PREFIX_W-1:0] best_ff, best_in;
   logic [HW_W-1:0]     hw_ff, hw_in;
   logic [IP_W-1:0]     dst_ff, dst_in;
   entry_type           rd_entry_ff;
   logic                rd_valid_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [HW_W-1:0]     rsp_hw_ff, rsp_hw_in;

   logic [OPCODE_W-1:0]   opcode;
   logic [SLOT_W-1:0]     slot;
   logic [SLOT_EXT_W-1:0] slot_ext;
   logic                  slot_ok;
   entry_type             new_entry;
   logic                  accept;
   logic                  tbl_we;
   logic [IDX_W-1:0]      tbl_waddr;
   logic                  vld_we;
   logic [IDX_W-1:0]      vld_waddr;
   logic                  vld_wdata;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic                  rsp_load;
   match_type             match;

   // Unpack the request.
   assign opcode           = req_tuser;
   assign slot             = req_tdata[SLOT_LSB +: SLOT_W];
   assign new_entry.ip     = req_tdata[IP_LSB +: IP_W];
   assign new_entry.mask   = req_tdata[MASK_LSB +: IP_W];
   assign new_entry.masked = req_tdata[MASKED_LSB +: IP_W];
   assign new_entry.prefix = req_tdata[PREFIX_LSB +: PREFIX_W];
   assign new_entry.hw     = req_tdata[HW_LSB +: HW_W];

   // Drop writes to slots beyond the table.
   assign slot_ext  = {{IDX_W{1'b0}}, slot};
   assign slot_ok   = (slot_ext < SLOT_EXT_W'(TABLE_DEPTH));
   assign tbl_waddr = slot_ext[IDX_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign tbl_we     = accept && (opcode == OP_WRITE) && slot_ok;

   // Valid port: clear sweep owns it in ST_CLEAR, writes set a flag otherwise.
   assign vld_we    = tbl_we || (state_ff == ST_CLEAR);
   assign vld_waddr = (state_ff == ST_CLEAR) ? cnt_ff[IDX_W-1:0] : tbl_waddr;
   assign vld_wdata = (state_ff != ST_CLEAR);

   // Scan read port: one slot per cycle.
   assign rd_en   = (state_ff == ST_SCAN) && (cnt_ff < CNT_W'(TABLE_DEPTH));
   assign rd_addr = cnt_ff[IDX_W-1:0];

   assign rsp_load = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp_tready);

   npl_match u_match (
      .entry (rd_entry_ff),
      .dst   (dst_ff),
      .best  (best_ff),
      .match (match)
   );

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= new_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= tbl_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (vld_we) begin
         valid_mem[vld_waddr] <= vld_wdata;
      end
      if (rd_en) begin
         rd_valid_ff <= valid_mem[rd_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      last_in      = 1'b0;
      hit_in       = hit_ff;
      stop_in      = stop_ff;
      best_in      = best_ff;
      hw_in        = hw_ff;
      dst_in       = dst_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_hw_in    = rsp_hw_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep one valid flag per cycle.
            if (cnt_ff == CNT_W'(TABLE_DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (opcode)
                  OP_LOOKUP: begin
                     dst_in   = req_tdata[DST_LSB +: IP_W];
                     hit_in   = 1'b0;
                     stop_in  = 1'b0;
                     best_in  = '0;
                     hw_in    = '0;
                     cnt_in   = '0;
                     state_in = ST_SCAN;
                  end
                  OP_CLEAR: begin
                     cnt_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     // Writes finish in the accept cycle; the unused code is dropped.
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Issue the next slot read.
            if (rd_en) begin
               pend_in = 1'b1;
               last_in = (cnt_ff == CNT_W'(TABLE_DEPTH - 1));
               cnt_in  = cnt_ff + CNT_W'(1);
            end
            // Score the slot read last cycle; an exact host hit ends the search.
            if (pend_ff && rd_valid_ff && !stop_ff) begin
               if (match.host_hit) begin
                  hit_in  = 1'b1;
                  stop_in = 1'b1;
                  hw_in   = rd_entry_ff.hw;
               end else if (match.net_hit) begin
                  hit_in  = 1'b1;
                  best_in = rd_entry_ff.prefix;
                  hw_in   = rd_entry_ff.hw;
               end
            end
            if (pend_ff && last_ff) begin
               cnt_in   = '0;
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            // Hold until the result register is free.
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_hw_in    = hit_ff ? hw_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         last_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         hit_ff       <= hit_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      hw_ff        <= hw_in;
      dst_ff       <= dst_in;
      rsp_found_ff <= rsp_found_in;
      rsp_hw_ff    <= rsp_hw_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - HW_W - 1){1'b0}}, rsp_hw_ff, rsp_found_ff};

`include "assert_macros.svh"

   // A miss always reports a zero hardware address.
   `ASSERT_IMPLIES(a_miss_zero_hw, clock, reset, rsp_valid_ff && !rsp_found_ff, rsp_hw_ff == '0)
   // A new result only comes out of the send state.
   `ASSERT_IMPLIES(a_rsp_from_send, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_SEND))
   // An early stop only follows a recorded hit.
   `ASSERT_IMPLIES(a_stop_has_hit, clock, reset, stop_ff, hit_ff)
   // The scan counter never runs past the table.
   `ASSERT_IMPLIES(a_cnt_range, clock, reset, state_ff == ST_SCAN, cnt_ff <= CNT_W'(TABLE_DEPTH))

endmodule

`default_nettype wire

// ===== rtl/core/npl_match.sv =====
// Shared slot matcher: exact host compare and masked prefix compare.
`default_nettype none

module npl_match (
   input  npl_pkg::entry_type             entry,
   input  logic [npl_pkg::IP_W-1:0]       dst,
   input  logic [npl_pkg::PREFIX_W-1:0]   best,
   output npl_pkg::match_type             match
);
   import npl_pkg::*;

   logic is_host;

   assign is_host        = (entry.prefix == HOST_PREFIX);
   assign match.host_hit = is_host && (entry.ip == dst);
   // Take a network entry only when strictly longer than the best so far.
   assign match.net_hit  = !is_host && ((dst & entry.mask) == entry.masked)
                           && (entry.prefix > best);

endmodule

`default_nettype wire

// ===== bench/npl_lookup_checker.sv =====
// Checker for the neighbor prefix lookup: mirrors the table and compares each lookup answer.
module npl_lookup_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [npl_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [npl_pkg::OPCODE_W-1:0]   req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [npl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             fail_count,
   output int                             pending_count
);
   import npl_pkg::*;

   localparam int FOUND_BIT   = 0;
   localparam int HW_ADDR_LSB = 1;

   typedef struct packed {
      logic            found;
      logic [HW_W-1:0] hw_addr;
   } answer_type;

   logic       table_valid [NPL_TABLE_DEPTH];
   entry_type  table_entry [NPL_TABLE_DEPTH];
   answer_type lookup_answers [$];
   int         mismatches = 0;

   // Scan in index order: a host entry with an equal address ends the scan,
   // a network entry wins only with a strictly longer prefix.
   function automatic answer_type resolve_neighbor(input logic [IP_W-1:0] dst);
      answer_type          answer;
      logic [PREFIX_W-1:0] best_len;
      bit                  done;
      answer   = '0;
      best_len = '0;
      done     = 1'b0;
      for (int i = 0; i < NPL_TABLE_DEPTH; i++) begin
         if (!done && table_valid[i]) begin
            if (table_entry[i].prefix == HOST_PREFIX) begin
               if (table_entry[i].ip == dst) begin
                  answer.found   = 1'b1;
                  answer.hw_addr = table_entry[i].hw;
                  done           = 1'b1;
               end
            end else if ((dst & table_entry[i].mask) == table_entry[i].masked &&
                         table_entry[i].prefix > best_len) begin
               answer.found   = 1'b1;
               answer.hw_addr = table_entry[i].hw;
               best_len       = table_entry[i].prefix;
            end
         end
      end
      return answer;
   endfunction

   always @(posedge clock) begin : monitor
      answer_type          got;
      answer_type          want;
      logic [SLOT_W-1:0]   slot_index;
      if (reset) begin
         foreach (table_valid[i]) table_valid[i] = 1'b0;
         lookup_answers.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_WRITE: begin
                  slot_index = req_tdata[SLOT_LSB +: SLOT_W];
                  if (int'(slot_index) < NPL_TABLE_DEPTH) begin
                     table_entry[slot_index].ip     = req_tdata[IP_LSB +: IP_W];
                     table_entry[slot_index].mask   = req_tdata[MASK_LSB +: IP_W];
                     table_entry[slot_index].masked = req_tdata[MASKED_LSB +: IP_W];
                     table_entry[slot_index].prefix = req_tdata[PREFIX_LSB +: PREFIX_W];
                     table_entry[slot_index].hw     = req_tdata[HW_LSB +: HW_W];
                     table_valid[slot_index]        = 1'b1;
                  end
               end
               OP_LOOKUP: begin
                  lookup_answers.push_back(resolve_neighbor(req_tdata[DST_LSB +: IP_W]));
               end
               OP_CLEAR: begin
                  foreach (table_valid[i]) table_valid[i] = 1'b0;
               end
               default: begin
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.found   = rsp_tdata[FOUND_BIT];
            got.hw_addr = rsp_tdata[HW_ADDR_LSB +: HW_W];
            if (lookup_answers.size() == 0) begin
               $display("%0t unexpected result: found %0b hw_addr %012h",
                        $time, got.found, got.hw_addr);
               mismatches++;
            end else begin
               want = lookup_answers.pop_front();
               if (got.found !== want.found) begin
                  $display("%0t found mismatch: expected %0b actual %0b",
                           $time, want.found, got.found);
                  mismatches++;
               end
               if (got.hw_addr !== want.hw_addr) begin
                  $display("%0t hw_addr mismatch: expected %012h actual %012h",
                           $time, want.hw_addr, got.hw_addr);
                  mismatches++;
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= lookup_answers.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// Top of the neighbor prefix lookup bench: clock, reset, request stimulus and verdict.
module tb_top;
   import npl_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   localparam int PHASE_ITEMS  = 225;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_BURST   = 12;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 2 * NPL_TABLE_DEPTH + 8;
   localparam int POOL_SIZE    = 16;

   localparam logic [HW_W-1:0] HW_ONES = {HW_W{1'b1}};
   localparam logic [IP_W-1:0] IP_ONES = {IP_W{1'b1}};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OPCODE_W-1:0]   req_tuser  = OP_WRITE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int fail_count;
   int pending_count;

   // Idle and stall rates of the current phase, in percent.
   int sender_idle_pct = 0;
   int stall_pct       = 0;

   // The stimulus bumps the ticket; the receiver serves it with a long hold-off.
   int hold_ticket = 0;
   int hold_served = 0;
   int hold_left   = 0;

   // Recently written addresses, reused to aim lookups at table entries.
   logic [IP_W-1:0] addr_pool [POOL_SIZE];

   neighbor_prefix_lookup i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   npl_lookup_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Receiver: serve a pending hold-off first, otherwise stall at the phase rate.
   always @(posedge clock) begin
      if (hold_ticket != hold_served) begin
         hold_served = hold_ticket;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: end the run if it takes far longer than the slowest correct run.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[neighbor_prefix_lookup] ERROR");
      $finish;
   end

   // Network mask with the top len bits set.
   function automatic logic [IP_W-1:0] prefix_mask(input int len);
      if (len <= 0) begin
         return '0;
      end
      return IP_ONES << (IP_W - len);
   endfunction

   function automatic logic [HW_W-1:0] random_hw();
      logic [31:0] upper;
      logic [31:0] lower;
      upper = $urandom;
      lower = $urandom;
      return {upper[HW_W-33:0], lower};
   endfunction

   // Pack request fields from the lowest bit up; the top bits stay zero.
   function automatic logic [REQ_DATA_W-1:0] pack_request(
      input logic [SLOT_W-1:0]   slot,
      input logic [IP_W-1:0]     ip,
      input logic [IP_W-1:0]     mask,
      input logic [IP_W-1:0]     masked,
      input logic [PREFIX_W-1:0] prefix,
      input logic [HW_W-1:0]     hw,
      input logic [IP_W-1:0]     dst
   );
      logic [REQ_DATA_W-1:0] data;
      data = '0;
      data[SLOT_LSB +: SLOT_W]     = slot;
      data[IP_LSB +: IP_W]         = ip;
      data[MASK_LSB +: IP_W]       = mask;
      data[MASKED_LSB +: IP_W]     = masked;
      data[PREFIX_LSB +: PREFIX_W] = prefix;
      data[HW_LSB +: HW_W]         = hw;
      data[DST_LSB +: IP_W]        = dst;
      return data;
   endfunction

   // Offer one request after a random gap and hold it until it is accepted.
   // Leave tvalid high afterwards so back-to-back requests keep streaming.
   task automatic offer_request(input logic [OPCODE_W-1:0] op,
                                input logic [REQ_DATA_W-1:0] data);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop tvalid and hold off until every predicted answer has come back.
   // The extra edge lets the checker count a lookup accepted at the last edge.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Build one random request. Most writes are well-formed network or host
   // entries, most lookups aim at or near stored addresses; the rest is noise.
   task automatic send_random_request(input bit lookup_only, output bit counted);
      int                  pick;
      int                  len;
      logic [OPCODE_W-1:0] op;
      logic [SLOT_W-1:0]   slot;
      logic [IP_W-1:0]     ip;
      logic [IP_W-1:0]     mask;
      logic [IP_W-1:0]     masked;
      logic [IP_W-1:0]     dst;
      logic [PREFIX_W-1:0] prefix;
      logic [HW_W-1:0]     hw;
      pick   = lookup_only ? 99 : $urandom_range(99);
      slot   = SLOT_W'($urandom_range(31));
      ip     = $urandom;
      mask   = $urandom;
      masked = $urandom;
      prefix = PREFIX_W'($urandom_range(63));
      hw     = random_hw();
      dst    = $urandom;
      op     = OP_LOOKUP;
      if (pick < 2) begin
         op = OP_CLEAR;
      end else if (pick < 5) begin
         op = OP_UNUSED;
      end else if (pick < 42) begin
         op   = OP_WRITE;
         pick = $urandom_range(99);
         if (pick < 20) begin
            // host entry, often on an address that is already routed
            prefix = HOST_PREFIX;
            if ($urandom_range(1)) ip = addr_pool[$urandom_range(POOL_SIZE - 1)];
         end else if (pick < 90) begin
            // consistent network entry, overlapping earlier ones half the time
            len = $urandom_range(32);
            if ($urandom_range(1)) ip = addr_pool[$urandom_range(POOL_SIZE - 1)];
            prefix = len[PREFIX_W-1:0];
            mask   = prefix_mask(len);
            masked = ip & mask;
         end
         addr_pool[$urandom_range(POOL_SIZE - 1)] = ip;
      end else begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            dst = addr_pool[$urandom_range(POOL_SIZE - 1)];
         end else if (pick < 80) begin
            // keep a random number of top bits, scramble the rest
            dst = addr_pool[$urandom_range(POOL_SIZE - 1)] ^
                  ($urandom & ~prefix_mask($urandom_range(32)));
         end
      end
      counted = (op != OP_UNUSED);
      offer_request(op, pack_request(slot, ip, mask, masked, prefix, hw, dst));
   endtask

   initial begin : stimulus
      bit counted;
      int issued;
      foreach (addr_pool[i]) addr_pool[i] = $urandom;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, host entries, prefix ties, zero and
      // oversized prefixes, the unused opcode, clear, and all-zero/all-one fields.
      offer_request(OP_LOOKUP, pack_request(0, 0, 0, 0, 0, 0, 32'h0000_0000));
      offer_request(OP_WRITE,  pack_request(0, IP_ONES, IP_ONES, IP_ONES, HOST_PREFIX,
                                            HW_ONES, 0));
      offer_request(OP_LOOKUP, pack_request(0, 0, 0, 0, 0, 0, IP_ONES));
      offer_request(OP_WRITE,  pack_request(3, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0000,
                                            6'd8, 48'h0000_0000_0A08, 0));
      offer_request(OP_WRITE,  pack_request(4, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0000,
                                            6'd16, 48'h0000_0000_0A16, 0));
      // equal prefix at a lower index: the earlier slot keeps the match
      offer_request(OP_WRITE,  pack_request(2, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0000,
                                            6'd16, 48'h0000_0000_0216, 0));
      offer_request(OP_LOOKUP, pack_request(0, 0, 0, 0, 0, 0, 32'h0A01_0203));
      offer_request(OP_LOOKUP, pack_request(0, 0, 0, 0, 0, 0, 32'h0A02_0304));
      // zero prefix matches everything but never wins
      offer_request(OP_WRITE,  pack_request(1, 0, 0, 0, 6'd0, 48'h0101_0101_0101, 0));
      offer_request(OP_LOOKUP, pack_request(0, 0, 0, 0, 0, 0, 32'h0B00_0000));
      // host entry after longer network matches still ends the scan with its own address
      offer_request(OP_WRITE,  pack_request(10, 32'h0A01_0203, 32'hFFFF_0000, 32'h0A01_0000,
                                            HOST_PREFIX, 48'h0000_0000_1010, 0));
      offer_request(OP_LOOKUP, pack_request(0, 0, 0, 0, 0, 0, 32'h0A01_0203));
      // prefix beyond 32 compares as a plain number
      offer_request(OP_WRITE,  pack_request(31, 0, 0, 0, 6'd63, 48'h0, 0));
      offer_request(OP_LOOKUP, pack_request(0, 0, 0, 0, 0, 0, 32'h0B00_0000));
      offer_request(OP_LOOKUP, pack_request(0, 0, 0, 0, 0, 0, 32'h0A01_0203));
      offer_request(OP_WRITE,  pack_request(30, 0, IP_ONES, 32'h0C00_0000, 6'd33,
                                            48'h0000_0000_3033, 0));
      offer_request(OP_LOOKUP, pack_request(0, 0, 0, 0, 0, 0, 32'h0C00_0000));
      // unused opcode with every data bit set: no table change, no result
      offer_request(OP_UNUSED, {REQ_DATA_W{1'b1}});
      offer_request(OP_CLEAR,  pack_request(0, 0, 0, 0, 0, 0, 0));
      offer_request(OP_LOOKUP, pack_request(0, 0, 0, 0, 0, 0, 32'h0A01_0203));
      offer_request(OP_WRITE,  pack_request(31, IP_ONES, IP_ONES, IP_ONES, 6'd63,
                                            HW_ONES, IP_ONES));
      offer_request(OP_LOOKUP, pack_request(0, 0, 0, 0, 0, 0, IP_ONES));
      offer_request(OP_WRITE,  pack_request(0, 0, 0, 0, 0, 0, 0));
      offer_request(OP_LOOKUP, pack_request(0, 0, 0, 0, 0, 0, 32'h0000_0000));
      wait_for_results();

      // Random part in four idling phases; pause for all answers between them.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               stall_pct       = 0;
            end
            1: begin
               sender_idle_pct = 53;
               stall_pct       = 0;
            end
            2: begin
               sender_idle_pct = 0;
               stall_pct       = 53;
            end
            default: begin
               sender_idle_pct = 34;
               stall_pct       = 34;
            end
         endcase
         issued = 0;
         while (issued < PHASE_ITEMS) begin
            if (phase == 0 && issued == PHASE_ITEMS / 2) begin
               // stall the result side for a long stretch and keep pushing
               // lookups so the result register fills and req_tready drops
               hold_ticket++;
               repeat (HOLD_BURST) send_random_request(1'b1, counted);
            end
            send_random_request(1'b0, counted);
            if (counted) issued++;
         end
         wait_for_results();
      end

      // Let any stray result show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[neighbor_prefix_lookup] OK");
      end else begin
         $display("[neighbor_prefix_lookup] ERROR");
      end
      $finish;
   end

endmodule
